### design/lcfe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED channel fade engine package
// Shared types and constants for the controller, the datapath and the top level.
// ----------------------------------------------------------------------------
package lcfe_pkg;

  typedef enum logic [2:0] {
    FN_SET_COLOR = 3'd0,
    FN_SET_FADE  = 3'd1,
    FN_DIRECT    = 3'd2,
    FN_TICK      = 3'd3,
    FN_SET_RUN   = 3'd4,
    FN_RUN_STEP  = 3'd5,
    FN_READ      = 3'd6
  } func_t;

  typedef struct packed {
    logic        down;
    logic [15:0] period;
    logic [15:0] countdown;
    logic [7:0]  steps;
    logic [7:0]  level;
  } chan_rec_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_RD,
    ST_EX,
    ST_DIV,
    ST_DIVWR,
    ST_ORD,
    ST_OWAIT
  } state_t;

  typedef struct packed {
    logic       start;
    logic       rd;
    logic       ex;
    logic       div_step;
    logic       div_wr;
    logic       ord;
    logic       oload;
    logic       first;
    logic       last;
    logic [1:0] sub;
  } cmd_t;

  typedef struct packed {
    logic scan;
    logic single;
    logic desc;
    logic need_div;
    logic out_free;
  } status_t;

  localparam int DivSteps = 16;
  localparam int FadesSat = 63;
  localparam int MaskLeds = 16;
  localparam logic [1:0] SubLast = 2'd2;

  localparam int InDataW  = 72;
  localparam int InUserW  = 3;
  localparam int OutDataW = 16;

endpackage

### design/lcfe_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and two read ports with registered read data.
// ----------------------------------------------------------------------------
module lcfe_ram #(
  parameter int Width = 8,
  parameter int Depth = 16,
  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [Width-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr0,
  output logic [Width-1:0] rdata0,
  input  logic [AW-1:0]    raddr1,
  output logic [Width-1:0] rdata1
);

  logic [Width-1:0] mem_r [Depth];
  logic [Width-1:0] rd0_r;
  logic [Width-1:0] rd1_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rd0_r <= mem_r[raddr0];
      rd1_r <= mem_r[raddr1];
    end
  end

  assign rdata0 = rd0_r;
  assign rdata1 = rd1_r;

endmodule

### design/lcfe_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fade engine controller
// Sequences the channel walk, the divider iterations and the result load.
// ----------------------------------------------------------------------------
module lcfe_ctrl #(
  parameter int NUM_LEDS = 16,
  localparam int LW = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  lcfe_pkg::status_t st,
  output lcfe_pkg::cmd_t   cmd,
  output logic [LW-1:0]    led
);

  localparam logic [LW-1:0] LedMax = LW'(NUM_LEDS - 1);

  lcfe_pkg::state_t state_r, state_nxt;
  logic [LW-1:0] led_r, led_nxt;
  logic [1:0]    sub_r, sub_nxt;
  logic [3:0]    div_cnt_r, div_cnt_nxt;
  logic          last_led;
  logic          done_ch;
  logic          advance;

  assign last_led = st.desc ? (led_r == '0) : (led_r == LedMax);
  assign done_ch  = st.single || (last_led && (sub_r == lcfe_pkg::SubLast));

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      lcfe_pkg::ST_IDLE:  if (in_valid) state_nxt = lcfe_pkg::ST_SETUP;
      lcfe_pkg::ST_SETUP: begin
        state_nxt = (st.scan || st.single) ? lcfe_pkg::ST_RD : lcfe_pkg::ST_ORD;
      end
      lcfe_pkg::ST_RD:    state_nxt = lcfe_pkg::ST_EX;
      lcfe_pkg::ST_EX: begin
        if (st.need_div) state_nxt = lcfe_pkg::ST_DIV;
        else state_nxt = done_ch ? lcfe_pkg::ST_ORD : lcfe_pkg::ST_RD;
      end
      lcfe_pkg::ST_DIV: begin
        if (div_cnt_r == 4'(lcfe_pkg::DivSteps - 1)) state_nxt = lcfe_pkg::ST_DIVWR;
      end
      lcfe_pkg::ST_DIVWR: state_nxt = done_ch ? lcfe_pkg::ST_ORD : lcfe_pkg::ST_RD;
      lcfe_pkg::ST_ORD:   state_nxt = lcfe_pkg::ST_OWAIT;
      lcfe_pkg::ST_OWAIT: if (st.out_free) state_nxt = lcfe_pkg::ST_IDLE;
      default:            state_nxt = lcfe_pkg::ST_IDLE;
    endcase
  end

  assign advance = ((state_r == lcfe_pkg::ST_EX) && !st.need_div) ||
                   (state_r == lcfe_pkg::ST_DIVWR);

  always_comb begin
    led_nxt     = led_r;
    sub_nxt     = sub_r;
    div_cnt_nxt = div_cnt_r;
    if (state_r == lcfe_pkg::ST_SETUP) begin
      led_nxt = st.desc ? LedMax : '0;
      sub_nxt = '0;
    end else if (advance && !done_ch) begin
      if (sub_r == lcfe_pkg::SubLast) begin
        sub_nxt = '0;
        led_nxt = st.desc ? led_r - LW'(1) : led_r + LW'(1);
      end else begin
        sub_nxt = sub_r + 2'd1;
      end
    end
    if (state_r == lcfe_pkg::ST_EX) div_cnt_nxt = '0;
    else if (state_r == lcfe_pkg::ST_DIV) div_cnt_nxt = div_cnt_r + 4'd1;
  end

  always_comb begin
    cmd          = '0;
    cmd.sub      = sub_r;
    cmd.first    = st.desc ? (led_r == LedMax) : (led_r == '0);
    cmd.last     = last_led;
    in_ready     = 1'b0;
    unique case (state_r)
      lcfe_pkg::ST_IDLE: begin
        in_ready  = 1'b1;
        cmd.start = in_valid;
      end
      lcfe_pkg::ST_RD:    cmd.rd       = 1'b1;
      lcfe_pkg::ST_EX:    cmd.ex       = 1'b1;
      lcfe_pkg::ST_DIV:   cmd.div_step = 1'b1;
      lcfe_pkg::ST_DIVWR: cmd.div_wr   = 1'b1;
      lcfe_pkg::ST_ORD:   cmd.ord      = 1'b1;
      lcfe_pkg::ST_OWAIT: cmd.oload    = st.out_free;
      default: ;
    endcase
  end

  assign led = led_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= lcfe_pkg::ST_IDLE;
      led_r     <= '0;
      sub_r     <= '0;
      div_cnt_r <= '0;
    end else begin
      state_r   <= state_nxt;
      led_r     <= led_nxt;
      sub_r     <= sub_nxt;
      div_cnt_r <= div_cnt_nxt;
    end
  end

endmodule

### design/lcfe_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fade engine datapath
// Channel state memory, per-channel update logic, period divider and result register.
// ----------------------------------------------------------------------------
module lcfe_dp #(
  parameter int NUM_LEDS = 16,
  localparam int LW = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  lcfe_pkg::cmd_t    cmd,
  input  logic [LW-1:0]     led,
  input  lcfe_pkg::func_t   func,
  input  logic [15:0]       led_mask,
  input  logic [7:0]        red,
  input  logic [7:0]        green,
  input  logic [7:0]        blue,
  input  logic [15:0]       fade_time,
  input  logic              direction,
  input  logic [5:0]        channel,
  input  logic [7:0]        value,
  input  logic              script_waiting,
  output lcfe_pkg::status_t st,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        channel_level,
  output logic [5:0]        fades_active,
  output logic              run_on
);

  localparam int NCH    = 3 * NUM_LEDS;
  localparam int CW     = $clog2(NCH);
  localparam int CntW   = $clog2(NCH + 1);
  localparam int RecW   = $bits(lcfe_pkg::chan_rec_t);
  localparam logic [LW-1:0] LedMax = LW'(NUM_LEDS - 1);

  lcfe_pkg::func_t op_r;
  logic [15:0] mask_r, ftime_r, run_ftime_r;
  logic [7:0]  red_r, green_r, blue_r, val_r;
  logic [5:0]  ch_r;
  logic        run_active_r, run_next_r, run_go_r;
  logic [NCH-1:0] valid_r;
  logic        rv0_r, rv1_r;
  logic [7:0]  saved_r [3];
  logic [15:0] dvd_r;
  logic [7:0]  rem_r;
  logic [CntW-1:0] fades_r;
  logic        out_valid_r;
  logic [7:0]  out_level_r;
  logic [5:0]  out_fades_r;
  logic        out_run_r;

  logic [RecW-1:0] rdata0, rdata1;
  lcfe_pkg::chan_rec_t rec, src_rec, nrec;
  logic          ch_ok, single, is_run, aim_op, led_sel, sel, down, need_div, we, re;
  logic [CW-1:0] ch_addr, scan_addr, addr0, src_addr;
  logic [LW-1:0] src_led;
  logic [7:0]    src_lvl, tgt, gap;
  logic [8:0]    rem_w;
  logic          ge;
  logic [15:0]   cd1;

  assign ch_ok  = (32'(ch_r) < NCH);
  assign single = (op_r == lcfe_pkg::FN_DIRECT) && ch_ok;
  assign is_run = (op_r == lcfe_pkg::FN_RUN_STEP);
  assign aim_op = (op_r == lcfe_pkg::FN_SET_FADE) || is_run;

  assign ch_addr   = CW'(ch_r);
  assign scan_addr = CW'(3 * int'(led) + int'(cmd.sub));
  assign addr0     = (cmd.ord || single) ? ch_addr : scan_addr;

  always_comb begin
    if (is_run && !run_next_r) src_led = (led == '0) ? LedMax : led - LW'(1);
    else src_led = (led == LedMax) ? '0 : led + LW'(1);
  end
  assign src_addr = CW'(3 * int'(src_led) + int'(cmd.sub));

  assign re = cmd.rd || cmd.ord;

  lcfe_ram #(.Width(RecW), .Depth(NCH)) u_ram (
    .clk    (clk),
    .we     (we),
    .waddr  (addr0),
    .wdata  (nrec),
    .re     (re),
    .raddr0 (addr0),
    .rdata0 (rdata0),
    .raddr1 (src_addr),
    .rdata1 (rdata1)
  );

  // Entries never written since reset read as all zero.
  assign rec     = rv0_r ? lcfe_pkg::chan_rec_t'(rdata0) : '0;
  assign src_rec = rv1_r ? lcfe_pkg::chan_rec_t'(rdata1) : '0;

  // The wrap-around neighbor was already rewritten in this walk, so its old level is kept.
  assign src_lvl = cmd.last ? saved_r[cmd.sub] : src_rec.level;

  always_comb begin
    if (is_run) tgt = src_lvl;
    else if (cmd.sub == 2'd0) tgt = blue_r;
    else if (cmd.sub == 2'd1) tgt = green_r;
    else tgt = red_r;
  end

  assign led_sel = (int'(led) < lcfe_pkg::MaskLeds) && mask_r[4'(led)];
  assign sel = ((op_r == lcfe_pkg::FN_SET_COLOR) || (op_r == lcfe_pkg::FN_SET_FADE)) ?
               led_sel : 1'b1;
  assign down     = rec.level > tgt;
  assign gap      = down ? rec.level - tgt : tgt - rec.level;
  assign need_div = aim_op && sel && (gap != 8'd0);
  assign we       = (cmd.ex && !need_div && sel) || cmd.div_wr;

  always_comb begin
    nrec = rec;
    cd1  = rec.countdown;
    case (op_r) inside
      lcfe_pkg::FN_SET_COLOR: begin
        nrec.level     = tgt;
        nrec.countdown = '0;
        nrec.steps     = '0;
      end
      lcfe_pkg::FN_DIRECT: begin
        nrec.level     = val_r;
        nrec.countdown = '0;
        nrec.steps     = '0;
      end
      lcfe_pkg::FN_TICK: begin
        if (rec.steps != 8'd0) begin
          if (rec.countdown != 16'd0) cd1 = rec.countdown - 16'd1;
          if (cd1 == 16'd0) begin
            nrec.steps     = rec.steps - 8'd1;
            nrec.countdown = rec.period;
            nrec.level     = rec.down ? rec.level - 8'd1 : rec.level + 8'd1;
          end else begin
            nrec.countdown = cd1;
          end
        end
      end
      lcfe_pkg::FN_SET_FADE, lcfe_pkg::FN_RUN_STEP: begin
        nrec.down = down;
        if (cmd.div_wr) begin
          nrec.period    = dvd_r;
          nrec.countdown = dvd_r;
          if (dvd_r == 16'd0) begin
            nrec.level = tgt;
            nrec.steps = '0;
          end else begin
            nrec.steps = gap;
          end
        end else begin
          nrec.level     = tgt;
          nrec.steps     = '0;
          nrec.countdown = '0;
        end
      end
      default: ;
    endcase
  end

  // Restoring divider, one quotient bit per step.
  assign rem_w = {rem_r, dvd_r[15]};
  assign ge    = rem_w >= {1'b0, gap};

  assign st.scan     = (op_r == lcfe_pkg::FN_SET_COLOR) || (op_r == lcfe_pkg::FN_SET_FADE) ||
                       (op_r == lcfe_pkg::FN_TICK) || (is_run && run_go_r);
  assign st.single   = single;
  assign st.desc     = is_run && !run_next_r;
  assign st.need_div = need_div;
  assign st.out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      op_r    <= func;
      mask_r  <= led_mask;
      red_r   <= red;
      green_r <= green;
      blue_r  <= blue;
      ftime_r <= fade_time;
      ch_r    <= channel;
      val_r   <= value;
    end
    if (re) begin
      rv0_r <= valid_r[addr0];
      rv1_r <= valid_r[src_addr];
    end
    if (cmd.ex && cmd.first) saved_r[cmd.sub] <= rec.level;
    if (cmd.ex) begin
      dvd_r <= is_run ? run_ftime_r : ftime_r;
      rem_r <= '0;
    end else if (cmd.div_step) begin
      dvd_r <= {dvd_r[14:0], ge};
      rem_r <= ge ? 8'(rem_w - {1'b0, gap}) : rem_w[7:0];
    end
    if (cmd.oload) begin
      out_level_r <= ch_ok ? rec.level : 8'd0;
      out_fades_r <= (32'(fades_r) > lcfe_pkg::FadesSat) ? 6'(lcfe_pkg::FadesSat) : 6'(fades_r);
      out_run_r   <= run_active_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_active_r <= 1'b0;
      run_next_r   <= 1'b0;
      run_ftime_r  <= '0;
      run_go_r     <= 1'b0;
      valid_r      <= '0;
      fades_r      <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cmd.start && (func == lcfe_pkg::FN_SET_RUN)) begin
        run_active_r <= 1'b1;
        run_next_r   <= direction;
        run_ftime_r  <= fade_time;
      end
      if (cmd.start && (func == lcfe_pkg::FN_RUN_STEP)) begin
        run_go_r <= run_active_r && script_waiting && (fades_r == '0);
        if (run_active_r && !script_waiting) run_active_r <= 1'b0;
      end
      if (we) begin
        valid_r[addr0] <= 1'b1;
        fades_r <= fades_r + CntW'(nrec.steps != 8'd0) - CntW'(rec.steps != 8'd0);
      end
      if (cmd.oload) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  assign out_valid     = out_valid_r;
  assign channel_level = out_level_r;
  assign fades_active  = out_fades_r;
  assign run_on        = out_run_r;

endmodule

### design/led_channel_fade_engine_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED channel fade engine
// Per-channel linear fader for an RGB LED strip with one result per command.
// ----------------------------------------------------------------------------
// One command is handled at a time. Set color, set fade, tick and an active run
// step walk all 3*NUM_LEDS channels through the state memory; each channel whose
// fade needs a period also runs the bit-serial 16-by-8 divider. Direct write updates
// only its own channel; read, set run and idle run steps go straight to the result.
// The result sits in an output register, so the next command is taken while it waits.
// After reset the block is ready at once: per-entry valid bits make unwritten
// channel state read as zero.
module led_channel_fade_engine_core #(
  parameter int NUM_LEDS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // led_mask[15:0], red[23:16], green[31:24], blue[39:32], fade_time[55:40],
  // direction[56], channel[62:57], value[70:63], script_waiting[71]
  input  logic [71:0] in_tdata,
  // func[2:0]
  input  logic [2:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // channel_level[7:0], fades_active[13:8], run_on[14], zero[15]
  output logic [15:0] out_tdata
);

  localparam int LW = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;

  lcfe_pkg::cmd_t    cmd;
  lcfe_pkg::status_t st;
  logic [LW-1:0]     led;
  logic [7:0]        channel_level;
  logic [5:0]        fades_active;
  logic              run_on;

  lcfe_ctrl #(.NUM_LEDS(NUM_LEDS)) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .st       (st),
    .cmd      (cmd),
    .led      (led)
  );

  lcfe_dp #(.NUM_LEDS(NUM_LEDS)) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .led            (led),
    .func           (lcfe_pkg::func_t'(in_tuser)),
    .led_mask       (in_tdata[15:0]),
    .red            (in_tdata[23:16]),
    .green          (in_tdata[31:24]),
    .blue           (in_tdata[39:32]),
    .fade_time      (in_tdata[55:40]),
    .direction      (in_tdata[56]),
    .channel        (in_tdata[62:57]),
    .value          (in_tdata[70:63]),
    .script_waiting (in_tdata[71]),
    .st             (st),
    .out_valid      (out_tvalid),
    .out_ready      (out_tready),
    .channel_level  (channel_level),
    .fades_active   (fades_active),
    .run_on         (run_on)
  );

  assign out_tdata = {1'b0, run_on, fades_active, channel_level};

  // A transfer starts a command, so the block is busy on the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input accepted while a command was still in progress");

  // The fade count can never exceed the number of channels.
  a_fades_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (32'(out_tdata[13:8]) <= 3 * NUM_LEDS))
    else $error("fade count larger than the channel count");

endmodule
